// ----- hw/rtl/psd_pkg.sv -----
package psd_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int QUEUE_DEPTH         = 4;
   localparam int CSR_INDEX_WIDTH     = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PERIODIC_YZ   = 2'd0,
      CSR_CELL_LENGTH_Y = 2'd1,
      CSR_CELL_LENGTH_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- hw/rtl/psd_front.sv -----
module psd_front #(
   parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_z,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_z,
   input  psd_pkg::queue_status_type    status,
   output logic                         push,
   output logic [3*(COORD_WIDTH+1)-1:0] push_data
);

   localparam int MW = COORD_WIDTH + 1;

   function automatic logic [MW-1:0] magnitude(input logic [COORD_WIDTH-1:0] a,
                                               input logic [COORD_WIDTH-1:0] b);
      logic [MW-1:0] d;
      d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
      return d[MW-1] ? (~d + MW'(1)) : d;
   endfunction

   logic               valid_ff, valid_in;
   logic [3*MW-1:0]    data_ff, data_in;
   logic               accept;

   assign push      = valid_ff && !status.full;
   assign req_ready = !valid_ff || !status.full;
   assign accept    = req_valid && req_ready;
   assign push_data = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         data_in  = {magnitude(req_first_x, req_second_x),
                     magnitude(req_first_y, req_second_y),
                     magnitude(req_first_z, req_second_z)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

// ----- hw/rtl/psd_queue.sv -----
module psd_queue #(
   parameter int WIDTH = 99,
   parameter int DEPTH = psd_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output psd_pkg::queue_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop) else $error("queue push while full");
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty) else $error("queue pop while empty");
   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count did not advance on push");

endmodule

// ----- hw/rtl/psd_back.sv -----
module psd_back #(
   parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   input  logic [3*(COORD_WIDTH+1)-1:0] item_data,
   output logic                         take,
   input  logic                         periodic_yz,
   input  logic [COORD_WIDTH-2:0]       cell_length_y,
   input  logic [COORD_WIDTH-2:0]       cell_length_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [COORD_WIDTH-1:0]       rsp_distance
);

   localparam int W  = COORD_WIDTH;
   localparam int MW = W + 1;
   localparam int NB = W + 2;
   localparam int RW = W + 1;
   localparam int SW = 2 * W + 2;

   logic en;

   logic          dv_ff  [NB+1];
   logic [MW-1:0] ax_ff  [NB+1];
   logic [MW-1:0] my_ff  [NB+1];
   logic [MW-1:0] mz_ff  [NB+1];
   logic          fy_ff  [NB+1];
   logic          fz_ff  [NB+1];
   logic [NB-1:0] ny_ff  [NB+1];
   logic [NB-1:0] nz_ff  [NB+1];
   logic [RW-1:0] ry_ff  [NB+1];
   logic [RW-1:0] rz_ff  [NB+1];

   logic          fv_ff;
   logic [MW-1:0] fax_ff, fay_ff, faz_ff;
   logic          sv_ff;
   logic [SW-1:0] sx_ff, sy_ff, sz_ff;

   logic          qv_ff   [W+1];
   logic [SW-1:0] qrem_ff [W+1];
   logic [W-1:0]  root_ff [W+1];

   logic [RW-1:0] div_y, div_z;

   assign div_y = {1'b0, cell_length_y, 1'b0};
   assign div_z = {1'b0, cell_length_z, 1'b0};

   assign en           = !qv_ff[W] || rsp_ready;
   assign take         = en && item_valid;
   assign rsp_valid    = qv_ff[W];
   assign rsp_distance = root_ff[W];

   function automatic logic [MW-1:0] fold_out(input logic [RW-1:0] rem,
                                              input logic [W-2:0] len);
      logic [W+1:0] d;
      d = {1'b0, rem} - {3'b000, len};
      if (d[W+1]) begin
         d = ~d + (W+2)'(1);
      end
      return d[W+1:1];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NB; i++) begin
            dv_ff[i] <= 1'b0;
         end
         fv_ff <= 1'b0;
         sv_ff <= 1'b0;
         for (int j = 0; j <= W; j++) begin
            qv_ff[j] <= 1'b0;
         end
      end else if (en) begin
         dv_ff[0] <= item_valid;
         for (int i = 1; i <= NB; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
         fv_ff    <= dv_ff[NB];
         sv_ff    <= fv_ff;
         qv_ff[0] <= sv_ff;
         for (int j = 1; j <= W; j++) begin
            qv_ff[j] <= qv_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [RW-1:0] ty, tz;
      logic [SW-1:0] trial;
      if (en) begin
         ax_ff[0] <= item_data[3*MW-1:2*MW];
         my_ff[0] <= item_data[2*MW-1:MW];
         mz_ff[0] <= item_data[MW-1:0];
         fy_ff[0] <= periodic_yz && (cell_length_y != '0);
         fz_ff[0] <= periodic_yz && (cell_length_z != '0);
         ny_ff[0] <= {item_data[2*MW-1:MW], 1'b0} + NB'(cell_length_y);
         nz_ff[0] <= {item_data[MW-1:0], 1'b0} + NB'(cell_length_z);
         ry_ff[0] <= '0;
         rz_ff[0] <= '0;
         for (int i = 1; i <= NB; i++) begin
            ax_ff[i] <= ax_ff[i-1];
            my_ff[i] <= my_ff[i-1];
            mz_ff[i] <= mz_ff[i-1];
            fy_ff[i] <= fy_ff[i-1];
            fz_ff[i] <= fz_ff[i-1];
            ny_ff[i] <= {ny_ff[i-1][NB-2:0], 1'b0};
            nz_ff[i] <= {nz_ff[i-1][NB-2:0], 1'b0};
            ty = {ry_ff[i-1][RW-2:0], ny_ff[i-1][NB-1]};
            tz = {rz_ff[i-1][RW-2:0], nz_ff[i-1][NB-1]};
            ry_ff[i] <= (ty >= div_y) ? ty - div_y : ty;
            rz_ff[i] <= (tz >= div_z) ? tz - div_z : tz;
         end

         fax_ff <= ax_ff[NB];
         fay_ff <= fy_ff[NB] ? fold_out(ry_ff[NB], cell_length_y) : my_ff[NB];
         faz_ff <= fz_ff[NB] ? fold_out(rz_ff[NB], cell_length_z) : mz_ff[NB];

         sx_ff <= SW'(fax_ff) * SW'(fax_ff);
         sy_ff <= SW'(fay_ff) * SW'(fay_ff);
         sz_ff <= SW'(faz_ff) * SW'(faz_ff);

         qrem_ff[0] <= sx_ff + sy_ff + sz_ff;
         root_ff[0] <= '0;
         for (int j = 1; j <= W; j++) begin
            trial = (SW'(root_ff[j-1]) << (W - j + 1)) | (SW'(1) << (2 * (W - j)));
            if (qrem_ff[j-1] >= trial) begin
               qrem_ff[j] <= qrem_ff[j-1] - trial;
               root_ff[j] <= root_ff[j-1] | (W'(1) << (W - j));
            end else begin
               qrem_ff[j] <= qrem_ff[j-1];
               root_ff[j] <= root_ff[j-1];
            end
         end
      end
   end

endmodule

// ----- hw/rtl/periodic_site_distance.sv -----
// Minimum-image distance of two 3D sites in signed fixed point.
// The request channel (req_valid, req_ready) carries the two site positions;
// the response channel (rsp_valid, rsp_ready) returns one distance per
// request, in request order, truncated toward zero and saturated at all ones.
// The csr_ port sets the periodic mode and the Y and Z cell lengths; it must
// only be written while no transaction is in flight.
// While nothing stalls, a new request is taken every cycle. From request to
// response, each request passes the front stage register, a queue entry, the
// load stage and the one-bit-per-stage image fold division, then the fold,
// square and sum registers, and the one-bit-per-stage square root.
// When the receiver holds rsp_ready low while a response is waiting, the back
// pipeline freezes, the queue between front and back fills, and req_ready
// drops once the queue and the front stage are both full.
// Reset clears all valid state and loads periodic mode off and both cell
// lengths as 1.0; requests are accepted in the cycle after reset is released.
module periodic_site_distance #(
   parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = psd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COORD_WIDTH-1:0]         req_first_x,
   input  logic signed [COORD_WIDTH-1:0]         req_first_y,
   input  logic signed [COORD_WIDTH-1:0]         req_first_z,
   input  logic signed [COORD_WIDTH-1:0]         req_second_x,
   input  logic signed [COORD_WIDTH-1:0]         req_second_y,
   input  logic signed [COORD_WIDTH-1:0]         req_second_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [COORD_WIDTH-1:0]                rsp_distance,
   input  logic                                  csr_write_enable,
   input  logic [psd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [COORD_WIDTH-2:0]                csr_write_data
);

   localparam int QW = 3 * (COORD_WIDTH + 1);

   logic                       periodic_ff;
   logic [COORD_WIDTH-2:0]     len_y_ff, len_z_ff;
   logic                       push, pop;
   logic [QW-1:0]              push_data, pop_data;
   psd_pkg::queue_status_type  status;

   always_ff @(posedge clock) begin
      if (reset) begin
         periodic_ff <= 1'b0;
         len_y_ff    <= (COORD_WIDTH-1)'(1) << FRAC_BITS;
         len_z_ff    <= (COORD_WIDTH-1)'(1) << FRAC_BITS;
      end else if (csr_write_enable) begin
         unique case (psd_pkg::csr_index_type'(csr_index))
            psd_pkg::CSR_PERIODIC_YZ:   periodic_ff <= csr_write_data[0];
            psd_pkg::CSR_CELL_LENGTH_Y: len_y_ff    <= csr_write_data;
            psd_pkg::CSR_CELL_LENGTH_Z: len_z_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   psd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_first_z  (req_first_z),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .req_second_z (req_second_z),
      .status       (status),
      .push         (push),
      .push_data    (push_data)
   );

   psd_queue #(.WIDTH(QW), .DEPTH(psd_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   psd_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (!status.empty),
      .item_data     (pop_data),
      .take          (pop),
      .periodic_yz   (periodic_ff),
      .cell_length_y (len_y_ff),
      .cell_length_z (len_z_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_distance  (rsp_distance)
   );

endmodule
